FILE: rtl/cvs_pkg.sv
// Package with shared constants, types and command codes for the cache victim selector.
package cvs_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_BITS   = 4;
    localparam int TICK_BITS  = 32;
    localparam int COUNT_BITS = 16;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ALLOC  = 3'd1;
    localparam logic [2:0] MODE_TOUCH  = 3'd2;
    localparam logic [2:0] MODE_FREE   = 3'd3;
    localparam logic [2:0] MODE_SELECT = 3'd4;

    localparam logic [1:0] POL_LRU = 2'd0;
    localparam logic [1:0] POL_LFU = 2'd1;
    localparam logic [1:0] POL_MIX = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;

    localparam logic [0:0] REG_POLICY = 1'd0;
    localparam logic [0:0] REG_WEIGHT = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic update;   // apply tick, allocate, touch or free
        logic clr_scan; // start of a scan: clear running results
        logic scan_a;   // first pass step over entry r_idx (max count, oldest)
        logic scan_b;   // final pass step over entry r_idx (compare)
        logic div_start;
        logic div_sel;  // 0 frequency fraction, 1 recency fraction
        logic take_score;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic ent_valid;
    } t_stat;

endpackage

FILE: rtl/cvs_div.sv
// Serial restoring divider giving floor(num * 65536 / den) for num not above den.
module cvs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [16:0] o_q
);
    import cvs_pkg::*;

    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [16:0] r_q, n_q;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_diff;

    assign w_diff = {r_rem[31:0], 1'b0} - {1'b0, r_den};

    always_comb begin
        n_rem = r_rem; n_q = r_q; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            n_rem = {1'b0, i_num};
            n_cnt = 5'd0;
            if (i_den == 32'd0) begin
                n_q = 17'd0; n_done = 1'b1; n_busy = 1'b0;
            end else if (i_num >= i_den) begin
                n_q = 17'h10000; n_done = 1'b1; n_busy = 1'b0;
            end else begin
                n_q = 17'd0; n_busy = 1'b1;
            end
        end else if (r_busy) begin
            // rem < den always, so 2*rem fits in 33 bits.
            if (!w_diff[32]) begin
                n_rem = w_diff;
                n_q   = {r_q[15:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], 1'b0};
                n_q   = {r_q[15:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= 5'd0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

FILE: rtl/cvs_datapath.sv
// Entry table, tick clock, scan registers and score comparison for the victim selector.
module cvs_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cvs_pkg::t_cmd             i_cmd,
    output cvs_pkg::t_stat            o_stat,
    input  logic [cvs_pkg::IDX_BITS-1:0] i_idx,
    input  logic [2:0]                i_mode,
    input  logic [3:0]                i_entry,
    input  logic [1:0]                i_policy,
    input  logic [8:0]                i_weight,
    output logic                      o_reject,
    output logic                      o_found,
    output logic [3:0]                o_victim
);
    import cvs_pkg::*;

    logic [ENTRIES-1:0]    r_valid;
    logic [TICK_BITS-1:0]  r_last [ENTRIES];
    logic [COUNT_BITS-1:0] r_count [ENTRIES];
    logic [TICK_BITS-1:0]  r_now;
    logic [COUNT_BITS-1:0] r_maxc;
    logic [TICK_BITS-1:0]  r_oldest;
    logic                  r_found;
    logic [IDX_BITS-1:0]   r_best;
    logic [TICK_BITS-1:0]  r_best_last;
    logic [COUNT_BITS-1:0] r_best_cnt;
    logic [25:0]           r_best_score;
    logic [16:0]           r_nf;
    logic [25:0]           r_score;

    logic [TICK_BITS-1:0]  w_last, w_age, w_range;
    logic [COUNT_BITS-1:0] w_cnt;
    logic                  w_ev, w_better;
    logic [8:0]            w_w;
    logic [31:0]           w_num, w_den;
    logic                  w_ddone;
    logic [16:0]           w_q, w_rec;
    logic [IDX_BITS-1:0]   w_e;

    assign w_e    = i_entry[IDX_BITS-1:0];
    assign w_last = r_last[i_idx];
    assign w_cnt  = r_count[i_idx];
    assign w_ev   = r_valid[i_idx];
    assign w_age  = (w_last > r_now) ? '0 : r_now - w_last;
    assign w_range = (r_now - r_oldest == '0) ? 32'd1 : r_now - r_oldest;
    assign w_w    = (i_weight > 9'd256) ? 9'd256 : i_weight;
    assign w_num  = i_cmd.div_sel ? w_age : {16'd0, w_cnt};
    assign w_den  = i_cmd.div_sel ? w_range : {16'd0, r_maxc};
    assign w_rec  = 17'h10000 - w_q;

    cvs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_ddone), .o_q(w_q)
    );

    always_comb begin
        unique case (i_policy)
            POL_LFU: w_better = !r_found || (w_cnt < r_best_cnt);
            POL_MIX: w_better = !r_found || (r_score < r_best_score);
            default: w_better = (w_last < r_now) && (!r_found || (w_last < r_best_last));
        endcase
    end

    assign o_reject = (i_mode == MODE_ALLOC) ? r_valid[w_e] :
                      (i_mode == MODE_TOUCH || i_mode == MODE_FREE) ? !r_valid[w_e] :
                      (i_mode == MODE_TICK || i_mode == MODE_SELECT) ? 1'b0 : 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_now   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.update && !o_reject) begin
                unique case (i_mode)
                    MODE_TICK:  if (r_now != '1) r_now <= r_now + 1'b1;
                    MODE_ALLOC: r_valid[w_e] <= 1'b1;
                    MODE_FREE:  r_valid[w_e] <= 1'b0;
                    default: ;
                endcase
            end
            if (i_cmd.clr_scan) r_found <= 1'b0;
            else if (i_cmd.scan_b && w_ev && w_better) r_found <= 1'b1;
        end
        // Entry payload: a free clears the fields to zero; reset leaves them as they are.
        if (i_cmd.update && !o_reject) begin
            if (i_mode == MODE_ALLOC || i_mode == MODE_FREE) begin
                r_last[w_e]  <= (i_mode == MODE_ALLOC) ? r_now : '0;
                r_count[w_e] <= '0;
            end else if (i_mode == MODE_TOUCH) begin
                r_last[w_e] <= r_now;
                if (r_count[w_e] != '1) r_count[w_e] <= r_count[w_e] + 1'b1;
            end
        end
        if (i_cmd.clr_scan) begin
            r_maxc   <= 16'd1;
            r_oldest <= r_now;
        end else if (i_cmd.scan_a && w_ev) begin
            if (w_cnt > r_maxc) r_maxc <= w_cnt;
            if (w_last < r_oldest) r_oldest <= w_last;
        end
        if (w_ddone && !i_cmd.div_sel) r_nf <= w_q;
        if (i_cmd.take_score)
            r_score <= 26'(w_w) * 26'(r_nf) + 26'(9'd256 - w_w) * 26'(w_rec);
        if (i_cmd.scan_b && w_ev && w_better) begin
            r_best       <= i_idx;
            r_best_last  <= w_last;
            r_best_cnt   <= w_cnt;
            r_best_score <= r_score;
        end
    end

    assign o_stat.div_done  = w_ddone;
    assign o_stat.ent_valid = w_ev;
    assign o_found  = r_found;
    assign o_victim = r_best;

`ifndef SYNTHESIS
    a_now_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_now >= $past(r_now)) else $error("tick went back");
    a_free_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !o_reject && i_mode == MODE_FREE) |=> !r_valid[$past(w_e)])
        else $error("free left entry valid");
    a_maxc_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_b |-> r_maxc != '0) else $error("zero max count");
`endif

endmodule

FILE: rtl/cvs_ctrl.sv
// Controller sequencing updates and the victim scans over the entry table.
module cvs_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_mode,
    input  logic [1:0]                   i_policy,
    input  cvs_pkg::t_stat               i_stat,
    output cvs_pkg::t_cmd                o_cmd,
    output logic [cvs_pkg::IDX_BITS-1:0] o_idx,
    output logic                         o_res_load,
    input  logic                         i_out_free
);
    import cvs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_PASSA = 3'd1, S_PASSB = 3'd2,
                           S_DNF = 3'd3, S_DREC = 3'd4, S_CMP = 3'd5, S_DONE = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic                r_wait, n_wait;
    logic                w_last_idx, w_mix;

    assign w_last_idx = (r_idx == IDX_BITS'(ENTRIES - 1));
    assign w_mix      = (i_policy == POL_MIX);
    assign o_idx      = r_idx;
    assign o_in_ready = (r_state == S_IDLE) && i_out_free;

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_wait = 1'b0;
        o_cmd = '0; o_res_load = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) begin
                if (i_mode == MODE_SELECT) begin
                    o_cmd.clr_scan = 1'b1; n_idx = '0;
                    n_state = w_mix ? S_PASSA : S_PASSB;
                end else begin
                    o_cmd.update = 1'b1; o_res_load = 1'b1;
                end
            end
            S_PASSA: begin
                o_cmd.scan_a = 1'b1; n_idx = r_idx + 1'b1;
                if (w_last_idx) begin n_idx = '0; n_state = S_DNF; n_wait = 1'b1; end
            end
            S_DNF: begin
                o_cmd.div_sel = 1'b0;
                if (r_wait) begin
                    if (i_stat.ent_valid) o_cmd.div_start = 1'b1;
                    else n_state = S_CMP;
                end else if (i_stat.div_done) begin
                    n_state = S_DREC; n_wait = 1'b1;
                end
            end
            S_DREC: begin
                o_cmd.div_sel = 1'b1;
                if (r_wait) o_cmd.div_start = 1'b1;
                else if (i_stat.div_done) begin o_cmd.take_score = 1'b1; n_state = S_CMP; end
            end
            S_CMP: begin
                o_cmd.scan_b = 1'b1; n_idx = r_idx + 1'b1;
                if (w_last_idx) n_state = S_DONE;
                else begin n_state = S_DNF; n_wait = 1'b1; end
            end
            S_PASSB: begin
                o_cmd.scan_b = 1'b1; n_idx = r_idx + 1'b1;
                if (w_last_idx) n_state = S_DONE;
            end
            S_DONE: begin o_res_load = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_idx <= '0; r_wait <= 1'b0;
        end else begin
            r_state <= n_state; r_idx <= n_idx; r_wait <= n_wait;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready while busy");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.update, o_cmd.scan_a, o_cmd.scan_b})) else $error("command clash");
    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> o_res_load) else $error("result lost");
`endif

endmodule

FILE: rtl/cache_victim_selector.sv
// Top level of the cache victim selector: stream ports, registers and result word.
//  channel | direction | handshake             | contents
//  s_axis  | in        | tvalid/tready         | tdata[2:0] mode, [6:3] entry
//  m_axis  | out       | tvalid/tready         | tdata[1:0] status, [5:2] victim
//  cfg     | in        | i_cfg_we              | index 0 policy, 1 frequency_weight
// Tick, allocate, touch, free apply when taken; LRU/LFU select scans each entry.
// Weighted select: a first pass, then the one divider runs twice per valid entry.
// A new word is taken only when the output register is empty or being drained.
// Reset is synchronous, active low; it clears valid bits, tick, config and tvalid.
module cache_victim_selector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // mode [2:0], entry [6:3]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // status [1:0], victim [5:2]
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import cvs_pkg::*;

    logic [1:0] r_policy;
    logic [8:0] r_weight;
    logic [2:0] r_mode;
    logic [3:0] r_entry;
    logic       r_ovalid;
    logic [5:0] r_odata;
    t_cmd       w_cmd;
    t_stat      w_stat;
    logic [IDX_BITS-1:0] w_idx;
    logic       w_load, w_reject, w_found, w_out_free, w_acc;
    logic [3:0] w_victim;
    logic [2:0] w_mode;
    logic [3:0] w_entry;

    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_mode  = w_acc ? s_axis_tdata[2:0] : r_mode;
    assign w_entry = w_acc ? s_axis_tdata[6:3] : r_entry;

    cvs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_mode(s_axis_tdata[2:0]), .i_policy(r_policy),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_idx(w_idx), .o_res_load(w_load),
        .i_out_free(w_out_free)
    );

    cvs_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_idx(w_idx), .i_mode(w_mode), .i_entry(w_entry), .i_policy(r_policy),
        .i_weight(r_weight), .o_reject(w_reject), .o_found(w_found), .o_victim(w_victim)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_LRU;
            r_weight <= 9'd128;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_POLICY) r_policy <= i_cfg_data[1:0];
            if (i_cfg_we && i_cfg_index == REG_WEIGHT) r_weight <= i_cfg_data;
            if (w_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
        if (w_acc) begin
            r_mode  <= s_axis_tdata[2:0];
            r_entry <= s_axis_tdata[6:3];
        end
        if (w_load) begin
            if (w_mode == MODE_SELECT)
                r_odata <= w_found ? {w_victim, ST_DONE} : {4'd0, ST_NONE};
            else
                r_odata <= {4'd0, w_reject ? ST_REJECT : ST_DONE};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_odata};

endmodule

FILE: tb/tb_cache_victim_selector.sv
// Self-checking testbench for the cache victim selector: table operations and all victim rules.
module tb_cache_victim_selector;
    import cvs_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // mode [2:0], entry [6:3]
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // status [1:0], victim [5:2]
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [8:0] i_cfg_data;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] victim;
    } t_answer;

    // Shadow copy of the table and registers.
    logic                  tbl_valid [ENTRIES];
    logic [TICK_BITS-1:0]  tbl_last  [ENTRIES];
    logic [COUNT_BITS-1:0] tbl_count [ENTRIES];
    logic [TICK_BITS-1:0]  tbl_now;
    logic [1:0]            cur_policy;
    logic [8:0]            cur_weight;

    t_answer answer_q[$];
    int      n_errors;
    int      idle_pct;
    int      rx_hold;
    int      quiet_cycles;

    cache_victim_selector u_dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        n_errors++;
    endtask

    // floor(num * 65536 / den), num <= den.
    function automatic logic [16:0] frac_q16(input logic [63:0] num, input logic [63:0] den);
        if (den == 0) return 0;
        if (num >= den) return 17'h10000;
        return 17'((num << 16) / den);
    endfunction

    function automatic int choose_victim();
        int best;
        logic [63:0] maxc, oldest, range, w, score, best_score, age;
        best = -1;
        best_score = 0;
        if (cur_policy == POL_LFU) begin
            for (int i = 0; i < ENTRIES; i++)
                if (tbl_valid[i] && (best < 0 || tbl_count[i] < tbl_count[best])) best = i;
        end else if (cur_policy == POL_MIX) begin
            maxc = 1;
            oldest = tbl_now;
            for (int i = 0; i < ENTRIES; i++) if (tbl_valid[i]) begin
                if (tbl_count[i] > maxc) maxc = tbl_count[i];
                if (tbl_last[i] < oldest) oldest = tbl_last[i];
            end
            range = tbl_now - oldest;
            if (range < 1) range = 1;
            w = (cur_weight > 256) ? 256 : cur_weight;
            for (int i = 0; i < ENTRIES; i++) if (tbl_valid[i]) begin
                age = (tbl_last[i] > tbl_now) ? 0 : tbl_now - tbl_last[i];
                score = w * frac_q16(tbl_count[i], maxc)
                      + (256 - w) * (65536 - frac_q16(age, range));
                if (best < 0 || score < best_score) begin
                    best = i;
                    best_score = score;
                end
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++)
                if (tbl_valid[i] && tbl_last[i] < tbl_now &&
                    (best < 0 || tbl_last[i] < tbl_last[best])) best = i;
        end
        return best;
    endfunction

    function automatic t_answer apply_command(input logic [2:0] mode, input logic [3:0] idx);
        t_answer a;
        int v;
        a = '0;
        case (mode)
            MODE_TICK: if (tbl_now != '1) tbl_now++;
            MODE_ALLOC: if (tbl_valid[idx]) a.status = ST_REJECT;
                else begin
                    tbl_valid[idx] = 1'b1;
                    tbl_last[idx]  = tbl_now;
                    tbl_count[idx] = '0;
                end
            MODE_TOUCH: if (!tbl_valid[idx]) a.status = ST_REJECT;
                else begin
                    tbl_last[idx] = tbl_now;
                    if (tbl_count[idx] != '1) tbl_count[idx]++;
                end
            MODE_FREE: if (!tbl_valid[idx]) a.status = ST_REJECT;
                else begin
                    tbl_valid[idx] = 1'b0;
                    tbl_last[idx]  = '0;
                    tbl_count[idx] = '0;
                end
            MODE_SELECT: begin
                v = choose_victim();
                if (v < 0) a.status = ST_NONE;
                else a.victim = 4'(v);
            end
            default: a.status = ST_REJECT;
        endcase
        return a;
    endfunction

    // The word stays offered between back-to-back calls; it is dropped only while idling or draining.
    task automatic send_word(input logic [2:0] mode, input logic [3:0] idx);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, idx, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        answer_q = {answer_q, apply_command(mode, idx)};
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_POLICY) cur_policy = value[1:0];
        else cur_weight = value;
    endtask

    // Result checker and receiver stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answer_q.size() == 0) report_mismatch("unexpected word", 1, 0);
            else begin
                t_answer want;
                want = answer_q.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    report_mismatch("status", int'(m_axis_tdata[1:0]), int'(want.status));
                if (m_axis_tdata[5:2] != want.victim)
                    report_mismatch("victim", int'(m_axis_tdata[5:2]), int'(want.victim));
            end
        end
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog on cycles with no accepted word.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("FAIL cache_victim_selector");
            $finish;
        end
    end

    task automatic test_basic_ops();
        send_word(MODE_SELECT, 4'd0);        // empty table
        send_word(MODE_TOUCH, 4'd3);         // missing entry
        send_word(MODE_FREE, 4'd15);
        send_word(MODE_ALLOC, 4'd0);
        send_word(MODE_ALLOC, 4'd0);         // already present
        send_word(MODE_SELECT, 4'd0);        // nothing older than now
        send_word(MODE_TICK, 4'd0);
        send_word(MODE_ALLOC, 4'd15);
        send_word(MODE_TOUCH, 4'd15);
        send_word(MODE_SELECT, 4'd0);
        send_word(3'd5, 4'd9);               // undefined modes
        send_word(3'd7, 4'd6);
        send_word(MODE_FREE, 4'd0);
        send_word(MODE_SELECT, 4'd0);
    endtask

    task automatic test_policies();
        logic [1:0] pols[4] = '{POL_LFU, POL_MIX, 2'd3, POL_LRU};
        foreach (pols[p]) begin
            write_reg(REG_POLICY, 9'(pols[p]));
            for (int k = 0; k < 4; k++) send_word(MODE_ALLOC, 4'($urandom_range(15)));
            send_word(MODE_TICK, 4'd0);
            send_word(MODE_TOUCH, 4'd15);
            send_word(MODE_SELECT, 4'd0);
        end
        write_reg(REG_POLICY, 9'(POL_MIX));
        write_reg(REG_WEIGHT, 9'd0);   send_word(MODE_SELECT, 4'd0);
        write_reg(REG_WEIGHT, 9'd256); send_word(MODE_SELECT, 4'd0);
        write_reg(REG_WEIGHT, 9'd511); send_word(MODE_SELECT, 4'd0);
    endtask

    task automatic run_random(input int n_words);
        logic [2:0] mode;
        int r;
        for (int k = 0; k < n_words; k++) begin
            r = $urandom_range(99);
            if (r < 20) mode = MODE_TICK;
            else if (r < 40) mode = MODE_ALLOC;
            else if (r < 65) mode = MODE_TOUCH;
            else if (r < 75) mode = MODE_FREE;
            else if (r < 97) mode = MODE_SELECT;
            else mode = 3'($urandom_range(5, 7));
            send_word(mode, 4'($urandom));
        end
    endtask

    task automatic test_random();
        logic [8:0] weights[6] = '{9'd128, 9'd1, 9'd255, 9'd300, 9'd64, 9'd200};
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_POLICY, 9'($urandom_range(3)));
            write_reg(REG_WEIGHT, weights[ph % 6]);
            idle_pct = (ph == 5) ? 0 : 11;
            run_random(ph == 3 ? 40 : 80);
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_POLICY, 9'(POL_LRU));
        rx_hold = 300;
        run_random(30);
        drain();
        run_random(10);
    endtask

    initial begin
        n_errors = 0;
        idle_pct = 11;
        rx_hold = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_last[i]  = '0;
            tbl_count[i] = '0;
        end
        tbl_now = '0;
        cur_policy = POL_LRU;
        cur_weight = 9'd128;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_policies();
        test_random();
        test_backpressure();
        drain();
        if (n_errors == 0) $display("PASS cache_victim_selector");
        else $display("FAIL cache_victim_selector");
        $finish;
    end
endmodule
